// File: hdl/rgbc_pkg.sv
// Shared types and codes for the RGB565 draw mode compositor.
package rgbc_pkg;

  // Packed 5-6-5 spread: green in the upper half, red and blue in the lower half.
  localparam logic [31:0] PackMask = 32'h07e0_f81f;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CmdFill  = 2'd0;
  localparam logic [1:0] CmdMono  = 2'd1;
  localparam logic [1:0] CmdAlpha = 2'd2;

  // Draw modes.
  localparam logic [1:0] ModeComplement = 2'd0;
  localparam logic [1:0] ModeBgOnly     = 2'd1;
  localparam logic [1:0] ModeFgOnly     = 2'd2;
  localparam logic [1:0] ModeSolid      = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CfgDrawMode       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgInverseVideo   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgFgColor        = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgBgColor        = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgBackdropEnable = 3'd4;

  typedef struct packed {
    logic [1:0]  draw_mode;
    logic        inverse_video;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        backdrop_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] dest_pixel;
    logic [15:0] backdrop_pixel;
    logic [15:0] image_pixel;
    logic        image_present;
    logic        mask_bit;
    logic [3:0]  alpha_value;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] pixel_out;
  } result_t;

endpackage

// File: hdl/rgb565_draw_mode_compositor_core.sv
// Top level of the RGB565 draw mode compositor: stream ports, registers, two-stage pipe.
// Takes one pixel word per cycle while the output side is ready and returns one
// result word per pixel, through the input register, then the result register; the
// decode and 5-6-5 blend between the two registers are combinational. The result register
// frees as the word is taken, so input flow continues at full rate while the
// output side is ready. Configuration must be written through the cfg port only
// while no word is in flight, which the block does not enforce; cfg_ready_o is always high.
module rgb565_draw_mode_compositor_core import rgbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // dest_pixel[15:0], backdrop_pixel[31:16], image_pixel[47:32], mask_bit[48],
  // alpha_value[52:49], zero fill[55:53]
  input  logic [55:0]            s_axis_tdata,
  // command[1:0], image_present[2]
  input  logic [2:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_out[15:0]
  output logic [15:0]            m_axis_tdata,
  // write_enable[0]
  output logic                   m_axis_tuser
);

  cfg_t    cfg_q;
  item_t   item_d;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_d;
  result_t res_q;
  logic    res_valid_q;
  logic    res_free;
  logic    advance;
  logic    take_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_mode       <= ModeSolid;
      cfg_q.inverse_video   <= 1'b0;
      cfg_q.fg_color        <= 16'h0000;
      cfg_q.bg_color        <= 16'hffff;
      cfg_q.backdrop_enable <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDrawMode:       cfg_q.draw_mode       <= cfg_data_i[1:0];
        CfgInverseVideo:   cfg_q.inverse_video   <= cfg_data_i[0];
        CfgFgColor:        cfg_q.fg_color        <= cfg_data_i;
        CfgBgColor:        cfg_q.bg_color        <= cfg_data_i;
        CfgBackdropEnable: cfg_q.backdrop_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item_d.command        = s_axis_tuser[1:0];
  assign item_d.image_present  = s_axis_tuser[2];
  assign item_d.dest_pixel     = s_axis_tdata[15:0];
  assign item_d.backdrop_pixel = s_axis_tdata[31:16];
  assign item_d.image_pixel    = s_axis_tdata[47:32];
  assign item_d.mask_bit       = s_axis_tdata[48];
  assign item_d.alpha_value    = s_axis_tdata[52:49];

  // A stage moves on when the stage after it is empty or being emptied.
  assign res_free      = !res_valid_q || m_axis_tready;
  assign advance       = item_valid_q && res_free;
  assign s_axis_tready = !item_valid_q || res_free;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (res_free) begin
        res_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  rgbc_compose u_compose (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q.pixel_out;
  assign m_axis_tuser  = res_q.write_enable;

endmodule

// File: hdl/rgbc_blend.sv
// RGB565 alpha blend with alpha widened from 0..15 to 0..16.
module rgbc_blend import rgbc_pkg::*; (
  input  logic [15:0] c1_i,
  input  logic [15:0] c2_i,
  input  logic [3:0]  alpha_i,
  output logic [15:0] pixel_o
);

  logic [4:0]  w1;
  logic [4:0]  w2;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [31:0] sum;
  logic [31:0] spread;

  always_comb begin
    w1     = {1'b0, alpha_i} + {4'd0, alpha_i[3]};
    w2     = 5'd16 - w1;
    p1     = {c1_i, c1_i} & PackMask;
    p2     = {c2_i, c2_i} & PackMask;
    // Each channel has headroom for a weight of 16, so the sum cannot overflow.
    sum    = p1 * {27'd0, w1} + p2 * {27'd0, w2};
    spread = (sum >> 4) & PackMask;
    pixel_o = spread[15:0] | spread[31:16];
  end

endmodule

// File: hdl/rgbc_compose.sv
// Per-pixel command decode and operand selection for the compositor.
module rgbc_compose import rgbc_pkg::*; (
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [15:0] back;
  logic [15:0] cpl;
  logic        bit_eff;
  logic [3:0]  alpha_eff;
  logic [15:0] src;
  logic [15:0] blend_c1;
  logic [15:0] blend_c2;
  logic [15:0] blended;
  logic        we;
  logic [15:0] pix;

  assign back      = cfg_i.backdrop_enable ? item_i.backdrop_pixel : cfg_i.bg_color;
  assign cpl       = ~item_i.dest_pixel;
  assign bit_eff   = item_i.mask_bit ^ cfg_i.inverse_video;
  assign alpha_eff = item_i.alpha_value ^ {4{cfg_i.inverse_video}};
  assign src       = item_i.image_present ? item_i.image_pixel : cfg_i.fg_color;

  // Modes with odd codes blend over the background, the others over dest.
  always_comb begin
    case (cfg_i.draw_mode)
      ModeComplement: begin
        blend_c1 = item_i.dest_pixel;
        blend_c2 = cpl;
      end
      ModeBgOnly: begin
        blend_c1 = back;
        blend_c2 = item_i.dest_pixel;
      end
      ModeFgOnly: begin
        blend_c1 = item_i.dest_pixel;
        blend_c2 = src;
      end
      default: begin
        blend_c1 = back;
        blend_c2 = src;
      end
    endcase
  end

  rgbc_blend u_blend (
    .c1_i    (blend_c1),
    .c2_i    (blend_c2),
    .alpha_i (alpha_eff),
    .pixel_o (blended)
  );

  always_comb begin
    we  = 1'b0;
    pix = 16'd0;
    case (item_i.command)
      CmdFill: begin
        if (cfg_i.inverse_video) begin
          if (cfg_i.draw_mode[0]) begin
            we  = 1'b1;
            pix = back;
          end
        end else if (cfg_i.draw_mode[1]) begin
          we  = 1'b1;
          pix = cfg_i.fg_color;
        end else if (cfg_i.draw_mode == ModeComplement) begin
          we  = 1'b1;
          pix = cpl;
        end
      end
      CmdMono: begin
        case (cfg_i.draw_mode)
          ModeComplement: begin
            we  = bit_eff;
            pix = cpl;
          end
          ModeBgOnly: begin
            we  = !bit_eff;
            pix = back;
          end
          ModeFgOnly: begin
            we  = bit_eff;
            pix = cfg_i.fg_color;
          end
          default: begin
            we  = 1'b1;
            pix = bit_eff ? cfg_i.fg_color : back;
          end
        endcase
      end
      CmdAlpha: begin
        // An image cannot be drawn in the complement or background-only modes.
        we  = cfg_i.draw_mode[1] || !item_i.image_present;
        pix = blended;
      end
      default: begin
        we  = 1'b0;
        pix = 16'd0;
      end
    endcase
    result_o.write_enable = we;
    result_o.pixel_out    = we ? pix : 16'd0;
  end

endmodule

// File: test/rgb565_compositor_checker.sv
// Checker for the RGB565 compositor: mirrors the registers, predicts every pixel word and compares results.
module rgb565_compositor_checker import rgbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [55:0]            s_tdata_i,
  input  logic [2:0]             s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [15:0]            m_tdata_i,
  input  logic                   m_tuser_i,
  output int                     fail_count_o,
  output int                     checked_count_o,
  output int                     pending_o
);

  // Past this many failures the run keeps counting but stops printing.
  localparam int MaxReports = 100;

  cfg_t    draw_cfg;
  result_t expected_pixels[$];

  // Weight a (widened to 0..16) on c1 and the rest on c2, all three fields at once.
  function automatic logic [15:0] blend_565(logic [15:0] c1, logic [15:0] c2, logic [3:0] a);
    logic [4:0]  w;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p;
    w  = {1'b0, a} + {4'b0000, a[3]};
    p1 = {c1, c1} & PackMask;
    p2 = {c2, c2} & PackMask;
    p  = p1 * w + p2 * (32'd16 - w);
    p  = (p >> 4) & PackMask;
    p  = p | (p >> 16);
    return p[15:0];
  endfunction

  function automatic result_t predict_pixel(item_t px, cfg_t c);
    result_t     r;
    logic [15:0] back;
    logic [15:0] cpl;
    logic [15:0] top;
    logic        b;
    logic [3:0]  a;
    r    = '0;
    back = c.backdrop_enable ? px.backdrop_pixel : c.bg_color;
    cpl  = ~px.dest_pixel;
    top  = px.image_present ? px.image_pixel : c.fg_color;
    b    = px.mask_bit ^ c.inverse_video;
    a    = c.inverse_video ? ~px.alpha_value : px.alpha_value;
    case (px.command)
      CmdFill: begin
        // Inverse video ignores the foreground: bg-only and solid paint the background.
        if (c.inverse_video) begin
          if (c.draw_mode == ModeBgOnly || c.draw_mode == ModeSolid) r = {1'b1, back};
        end else if (c.draw_mode == ModeFgOnly || c.draw_mode == ModeSolid) begin
          r = {1'b1, c.fg_color};
        end else if (c.draw_mode == ModeComplement) begin
          r = {1'b1, cpl};
        end
      end
      CmdMono: begin
        case (c.draw_mode)
          ModeComplement: if (b) r = {1'b1, cpl};
          ModeBgOnly:     if (!b) r = {1'b1, back};
          ModeFgOnly:     if (b) r = {1'b1, c.fg_color};
          default:        r = {1'b1, b ? c.fg_color : back};
        endcase
      end
      CmdAlpha: begin
        // An image pixel has nothing to draw against in complement or bg-only mode.
        case (c.draw_mode)
          ModeComplement: if (!px.image_present) r = {1'b1, blend_565(px.dest_pixel, cpl, a)};
          ModeBgOnly:     if (!px.image_present) r = {1'b1, blend_565(back, px.dest_pixel, a)};
          ModeFgOnly:     r = {1'b1, blend_565(px.dest_pixel, top, a)};
          default:        r = {1'b1, blend_565(back, top, a)};
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t   px;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      draw_cfg.draw_mode       = ModeSolid;
      draw_cfg.inverse_video   = 1'b0;
      draw_cfg.fg_color        = 16'h0000;
      draw_cfg.bg_color        = 16'hffff;
      draw_cfg.backdrop_enable = 1'b0;
      expected_pixels.delete();
      fail_count_o    = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDrawMode:       draw_cfg.draw_mode       = cfg_data_i[1:0];
          CfgInverseVideo:   draw_cfg.inverse_video   = cfg_data_i[0];
          CfgFgColor:        draw_cfg.fg_color        = cfg_data_i;
          CfgBgColor:        draw_cfg.bg_color        = cfg_data_i;
          CfgBackdropEnable: draw_cfg.backdrop_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i};
        if (expected_pixels.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $error("result word with no pixel pending: write_enable %0b pixel_out %h",
                   got.write_enable, got.pixel_out);
        end else begin
          want = expected_pixels.pop_front();
          checked_count_o++;
          if (got.write_enable !== want.write_enable) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $error("write_enable: expected %0b, actual %0b",
                     want.write_enable, got.write_enable);
          end
          if (got.pixel_out !== want.pixel_out) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $error("pixel_out: expected %h, actual %h", want.pixel_out, got.pixel_out);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        px.command        = s_tuser_i[1:0];
        px.image_present  = s_tuser_i[2];
        px.dest_pixel     = s_tdata_i[15:0];
        px.backdrop_pixel = s_tdata_i[31:16];
        px.image_pixel    = s_tdata_i[47:32];
        px.mask_bit       = s_tdata_i[48];
        px.alpha_value    = s_tdata_i[52:49];
        expected_pixels.push_back(predict_pixel(px, draw_cfg));
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// File: test/rgb565_draw_mode_compositor_core_tb.sv
// Testbench top for the RGB565 compositor: clock, reset, pixel and register stimulus, verdict.
module rgb565_draw_mode_compositor_core_tb import rgbc_pkg::*;;

  localparam int RandomItems = 850;
  localparam int CycleLimit  = 300000;
  localparam int FlushCycles = 8;

  // Index past the last register; a write there must change nothing.
  localparam logic [CfgIdxWidth-1:0] CfgIdxUnused = 3'd7;
  // The command code that the block must ignore.
  localparam logic [1:0] CmdUnknown = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [15:0]            cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [55:0]            s_axis_tdata;
  logic [2:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;
  logic                   m_axis_tuser;

  int fail_count;
  int checked_count;
  int pending;
  int cycle_count = 0;
  int sent_count  = 0;
  int cfg_writes  = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  rgb565_draw_mode_compositor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rgb565_compositor_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .fail_count_o    (fail_count),
    .checked_count_o (checked_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one; none in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_color();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic item_t rand_pixel();
    item_t px;
    int    r;
    r = $urandom_range(0, 15);
    px.command        = (r == 0) ? CmdUnknown : 2'($urandom_range(CmdAlpha, CmdFill));
    px.dest_pixel     = pick_color();
    px.backdrop_pixel = pick_color();
    px.image_pixel    = pick_color();
    px.image_present  = 1'($urandom_range(0, 1));
    px.mask_bit       = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 7);
    px.alpha_value    = (r == 0) ? 4'h0 : (r == 1) ? 4'hf : 4'($urandom_range(0, 15));
    return px;
  endfunction

  // The receiver stalls at random, independently of the sender.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Leaves tvalid high so that a following word can go out back to back.
  task automatic push_pixel(input item_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, px.alpha_value, px.mask_bit, px.image_pixel,
                      px.backdrop_pixel, px.dest_pixel};
    s_axis_tuser  <= {px.image_present, px.command};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  // The extra edge first lets the checker see a word accepted at the current edge.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    item_t px;
    int    len;
    int    phase;
    int    sent_random;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgDrawMode;
    cfg_data_i    = '0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every command in every mode, with and without inverse video,
    // the alpha extremes and image words in the modes that must drop them.
    write_reg(CfgFgColor, 16'hffff);
    write_reg(CfgBgColor, 16'h0000);
    cfg_valid_i <= 1'b0;
    for (int m = ModeComplement; m <= ModeSolid; m++) begin
      for (int inv = 0; inv < 2; inv++) begin
        drain_pipe();
        write_reg(CfgDrawMode, 16'(m));
        write_reg(CfgInverseVideo, 16'(inv));
        write_reg(CfgBackdropEnable, 16'(inv));
        cfg_valid_i <= 1'b0;
        px = rand_pixel();
        px.command    = CmdFill;
        px.dest_pixel = inv[0] ? 16'hffff : 16'h0000;
        push_pixel(px);
        px = rand_pixel();
        px.command  = CmdMono;
        px.mask_bit = m[0];
        push_pixel(px);
        px = rand_pixel();
        px.command       = CmdAlpha;
        px.image_present = inv[0];
        px.alpha_value   = m[0] ? 4'hf : 4'h0;
        push_pixel(px);
      end
    end
    px = rand_pixel();
    px.command = CmdUnknown;
    push_pixel(px);

    // Random phases, each under a fresh register setting taken while idle.
    phase       = 0;
    sent_random = 0;
    while (sent_random < RandomItems) begin
      drain_pipe();
      calm = ($urandom_range(0, 4) == 0);
      for (int r = CfgDrawMode; r <= CfgBackdropEnable; r++) begin
        if (phase == 0 || $urandom_range(0, 2) == 0)
          write_reg(CfgIdxWidth'(r), (r == CfgFgColor || r == CfgBgColor) ?
                                     pick_color() : 16'($urandom));
      end
      if (phase == 0) write_reg(CfgIdxUnused, 16'($urandom));
      cfg_valid_i <= 1'b0;
      len = $urandom_range(20, 80);
      repeat (len) begin
        push_pixel(rand_pixel());
        sent_random++;
      end
      phase++;
    end

    drain_pipe();
    repeat (FlushCycles) @(posedge clk_i);
    $display("Run covered %0d pixel words and %0d register writes over %0d random phases.",
             sent_count, cfg_writes, phase);
    $display("%0d result words compared, %0d failures.", checked_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rgbc_pkg.sv
hdl/rgbc_blend.sv
hdl/rgbc_compose.sv
hdl/rgb565_draw_mode_compositor_core.sv
test/rgb565_compositor_checker.sv
test/rgb565_draw_mode_compositor_core_tb.sv
